// ===== design/dual_sonar_pi_steering_assert.svh =====
// Assertion macros shared by the steering controller.
`ifndef DUAL_SONAR_PI_STEERING_ASSERT_SVH
`define DUAL_SONAR_PI_STEERING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSPS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("steering assertion failed");

// Next-cycle implication, checked outside reset.
`define DSPS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("steering assertion failed");

`endif

// ===== design/dsps_pkg.sv =====
`timescale 1ns / 1ps

package dsps_pkg;

   // Field and register widths.
   localparam int DIST_W  = 9;
   localparam int US_W    = 12;
   localparam int POS_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int SUM_W   = 32;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_NEUTRAL_US  = 3'd0,
      REG_MIN_US      = 3'd1,
      REG_MAX_US      = 3'd2,
      REG_START_LEFT  = 3'd3,
      REG_START_RIGHT = 3'd4,
      REG_JUMP_LIMIT  = 3'd5,
      REG_KP_Q8       = 3'd6,
      REG_KI_DT_Q16   = 3'd7
   } csr_index_type;

   // Register values after reset.
   localparam logic [US_W-1:0]   RST_NEUTRAL_US  = 12'd1490;
   localparam logic [US_W-1:0]   RST_MIN_US      = 12'd1000;
   localparam logic [US_W-1:0]   RST_MAX_US      = 12'd2000;
   localparam logic [DIST_W-1:0] RST_START_LEFT  = 9'd0;
   localparam logic [DIST_W-1:0] RST_START_RIGHT = 9'd0;
   localparam logic [DIST_W-1:0] RST_JUMP_LIMIT  = 9'd8;
   localparam logic [GAIN_W-1:0] RST_KP_Q8       = 16'd102;
   localparam logic [GAIN_W-1:0] RST_KI_DT_Q16   = 16'd213;

   // Saturate a 17-bit signed value to 16 bits.
   function automatic logic [POS_W-1:0] sat16(input logic [POS_W:0] v);
      logic [POS_W-1:0] r;
      if (v[POS_W] != v[POS_W-1]) begin
         r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   // Saturate a 33-bit signed value to 32 bits.
   function automatic logic [SUM_W-1:0] sat32(input logic [SUM_W:0] v);
      logic [SUM_W-1:0] r;
      if (v[SUM_W] != v[SUM_W-1]) begin
         r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/dual_sonar_pi_steering.sv =====
`timescale 1ns / 1ps

// PI steering controller fed by two side sonars. Each input word carries one
// distance; words alternate left, right, starting with left after reset. A
// reading that jumps from the previous reading of its side by more than
// jump_limit rebases that side's wall offset. Lateral position is right
// deviation minus left deviation, the error is its negation and feeds a
// saturating 32-bit integral. Steering is neutral + kp*error (Q8.8) +
// ki_dt*integral (Q0.16), truncated toward zero, clamped to max_us and then
// to min_us. Writing a start offset also reloads that side's offset and last
// reading. The block is a five-register pipeline (input, side update and
// integral, gain multipliers, sum, truncate and clamp): it takes one word per
// clock while the result side does not stall; each result passes through all
// these registers in order before it is offered. Write configuration only
// while no word is in flight.
module dual_sonar_pi_steering (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [8:0] distance_cm, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] steering_us, [27:12] lateral_pos, [31:28] zero
   output logic        rsp_tuser,   // [0] was_right
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

`include "dual_sonar_pi_steering_assert.svh"

   // Configuration registers.
   logic [dsps_pkg::US_W-1:0]   neutral_us_ff, min_us_ff, max_us_ff;
   logic [dsps_pkg::DIST_W-1:0] jump_limit_ff;
   logic [dsps_pkg::GAIN_W-1:0] kp_q8_ff, ki_dt_q16_ff;
   logic                        csr_write;
   dsps_pkg::csr_index_type     csr_sel;

   // Pipeline control.
   logic vld0_ff, vld1_ff, vld2_ff, vld3_ff, rsp_vld_ff;
   logic rdy1, rdy2, rdy3, rdy4, ld1, ld4;

   // Stage 0: input word.
   logic [dsps_pkg::DIST_W-1:0] dist_ff;

   // Controller state.
   logic                        turn_ff, turn_in;
   logic signed [15:0]          off_l_ff, off_l_in, off_r_ff, off_r_in;
   logic [dsps_pkg::DIST_W-1:0] last_l_ff, last_l_in, last_r_ff, last_r_in;
   logic signed [15:0]          dev_l_ff, dev_l_in, dev_r_ff, dev_r_in;
   logic signed [31:0]          esum_ff, esum_in;

   // Stage 1 working signals and registers.
   logic [dsps_pkg::DIST_W-1:0] cur_last;
   logic signed [15:0]          cur_off, new_off, new_dev, lateral_in;
   logic signed [9:0]           delta;
   logic [9:0]                  mag;
   logic                        jump;
   logic signed [16:0]          err_in;
   logic signed [16:0]          err1_ff;
   logic signed [15:0]          lat1_ff;
   logic                        right1_ff;

   // Stage 2: products.
   logic signed [33:0] kp_prod_in, kp_prod_ff;
   logic signed [48:0] ki_prod_in, ki_prod_ff;
   logic signed [15:0] lat2_ff;
   logic               right2_ff;

   // Stage 3: Q16 sum.
   logic signed [49:0] acc_in, acc_ff;
   logic signed [15:0] lat3_ff;
   logic               right3_ff;

   // Stage 4: truncation and clamp.
   logic signed [33:0]        quot, q;
   logic                      round_up, gt_max, lt_min;
   logic [dsps_pkg::US_W-1:0] steer_in, steer_ff;
   logic signed [15:0]        rsp_lat_ff;
   logic                      rsp_right_ff;

   // Configuration port: always ready.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_sel   = dsps_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_us_ff  <= dsps_pkg::RST_NEUTRAL_US;
         min_us_ff      <= dsps_pkg::RST_MIN_US;
         max_us_ff      <= dsps_pkg::RST_MAX_US;
         jump_limit_ff  <= dsps_pkg::RST_JUMP_LIMIT;
         kp_q8_ff       <= dsps_pkg::RST_KP_Q8;
         ki_dt_q16_ff   <= dsps_pkg::RST_KI_DT_Q16;
      end else if (csr_write) begin
         // The start offsets go straight into the controller state below.
         case (csr_sel)
            dsps_pkg::REG_NEUTRAL_US:  neutral_us_ff  <= csr_data[11:0];
            dsps_pkg::REG_MIN_US:      min_us_ff      <= csr_data[11:0];
            dsps_pkg::REG_MAX_US:      max_us_ff      <= csr_data[11:0];
            dsps_pkg::REG_JUMP_LIMIT:  jump_limit_ff  <= csr_data[8:0];
            dsps_pkg::REG_KP_Q8:       kp_q8_ff       <= csr_data;
            dsps_pkg::REG_KI_DT_Q16:   ki_dt_q16_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Each stage loads when it is empty or its content moves on.
   assign rdy4       = !rsp_vld_ff || rsp_tready;
   assign rdy3       = !vld3_ff || rdy4;
   assign rdy2       = !vld2_ff || rdy3;
   assign rdy1       = !vld1_ff || rdy2;
   assign req_tready = !vld0_ff || rdy1;
   assign ld1        = vld0_ff && rdy1;
   assign ld4        = vld3_ff && rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff    <= 1'b0;
         vld1_ff    <= 1'b0;
         vld2_ff    <= 1'b0;
         vld3_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            vld0_ff <= req_tvalid;
         end
         if (rdy1) begin
            vld1_ff <= vld0_ff;
         end
         if (rdy2) begin
            vld2_ff <= vld1_ff;
         end
         if (rdy3) begin
            vld3_ff <= vld2_ff;
         end
         if (rdy4) begin
            rsp_vld_ff <= vld3_ff;
         end
      end
   end

   // Stage 0: capture the distance.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         dist_ff <= req_tdata[8:0];
      end
   end

   // Stage 1: rebase the offset of the current side, form the deviation,
   // the lateral position, the error and the new integral.
   always_comb begin
      cur_last   = turn_ff ? last_r_ff : last_l_ff;
      cur_off    = turn_ff ? off_r_ff : off_l_ff;
      delta      = $signed({1'b0, dist_ff}) - $signed({1'b0, cur_last});
      mag        = delta[9] ? -delta : delta;
      jump       = mag > {1'b0, jump_limit_ff};
      new_off    = jump ? dsps_pkg::sat16({cur_off[15], cur_off} + {{7{delta[9]}}, delta})
                        : cur_off;
      new_dev    = dsps_pkg::sat16({8'b0, dist_ff} - {new_off[15], new_off});
      dev_l_in   = turn_ff ? dev_l_ff : new_dev;
      dev_r_in   = turn_ff ? new_dev : dev_r_ff;
      lateral_in = dsps_pkg::sat16({dev_r_in[15], dev_r_in} - {dev_l_in[15], dev_l_in});
      err_in     = -{lateral_in[15], lateral_in};
      esum_in    = dsps_pkg::sat32({esum_ff[31], esum_ff} + {{16{err_in[16]}}, err_in});
      turn_in    = !turn_ff;
      off_l_in   = turn_ff ? off_l_ff : new_off;
      off_r_in   = turn_ff ? new_off : off_r_ff;
      last_l_in  = turn_ff ? last_l_ff : dist_ff;
      last_r_in  = turn_ff ? dist_ff : last_r_ff;
   end

   // Controller state; a start offset write reloads that side.
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff   <= 1'b0;
         off_l_ff  <= $signed({7'b0, dsps_pkg::RST_START_LEFT});
         off_r_ff  <= $signed({7'b0, dsps_pkg::RST_START_RIGHT});
         last_l_ff <= dsps_pkg::RST_START_LEFT;
         last_r_ff <= dsps_pkg::RST_START_RIGHT;
         dev_l_ff  <= '0;
         dev_r_ff  <= '0;
         esum_ff   <= '0;
      end else if (csr_write && csr_sel == dsps_pkg::REG_START_LEFT) begin
         off_l_ff  <= $signed({7'b0, csr_data[8:0]});
         last_l_ff <= csr_data[8:0];
      end else if (csr_write && csr_sel == dsps_pkg::REG_START_RIGHT) begin
         off_r_ff  <= $signed({7'b0, csr_data[8:0]});
         last_r_ff <= csr_data[8:0];
      end else if (ld1) begin
         turn_ff   <= turn_in;
         off_l_ff  <= off_l_in;
         off_r_ff  <= off_r_in;
         last_l_ff <= last_l_in;
         last_r_ff <= last_r_in;
         dev_l_ff  <= dev_l_in;
         dev_r_ff  <= dev_r_in;
         esum_ff   <= esum_in;
      end
   end

   // The integral stays in esum_ff until stage 2 has taken this word.
   always_ff @(posedge clock) begin
      if (ld1) begin
         err1_ff   <= err_in;
         lat1_ff   <= lateral_in;
         right1_ff <= turn_ff;
      end
   end

   // Stage 2: proportional and integral products.
   assign kp_prod_in = $signed({1'b0, kp_q8_ff}) * err1_ff;
   assign ki_prod_in = $signed({1'b0, ki_dt_q16_ff}) * esum_ff;

   always_ff @(posedge clock) begin
      if (vld1_ff && rdy2) begin
         kp_prod_ff <= kp_prod_in;
         ki_prod_ff <= ki_prod_in;
         lat2_ff    <= lat1_ff;
         right2_ff  <= right1_ff;
      end
   end

   // Stage 3: sum of all three terms in Q16.
   assign acc_in = $signed({22'b0, neutral_us_ff, 16'b0})
                 + $signed({{8{kp_prod_ff[33]}}, kp_prod_ff, 8'b0})
                 + $signed({ki_prod_ff[48], ki_prod_ff});

   always_ff @(posedge clock) begin
      if (vld2_ff && rdy3) begin
         acc_ff    <= acc_in;
         lat3_ff   <= lat2_ff;
         right3_ff <= right2_ff;
      end
   end

   // Stage 4: drop the fraction toward zero, clamp to max and then to min.
   always_comb begin
      quot     = acc_ff[49:16];
      round_up = acc_ff[49] && (acc_ff[15:0] != 16'd0);
      q        = quot + $signed({33'b0, round_up});
      gt_max   = q > $signed({22'b0, max_us_ff});
      lt_min   = q < $signed({22'b0, min_us_ff});
      if (gt_max) begin
         steer_in = (max_us_ff < min_us_ff) ? min_us_ff : max_us_ff;
      end else if (lt_min) begin
         steer_in = min_us_ff;
      end else begin
         steer_in = q[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         steer_ff     <= steer_in;
         rsp_lat_ff   <= lat3_ff;
         rsp_right_ff <= right3_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0, rsp_lat_ff, steer_ff};
   assign rsp_tuser  = rsp_right_ff;

   // Sides alternate with every word that passes the side update, unless a start offset write comes in the same cycle.
   `DSPS_ASSERT_NEXT(a_side_alternates, ld1, turn_ff != $past(turn_ff))

   // A positive error never lowers the integral.
   `DSPS_ASSERT_NEXT(a_integral_rises, ld1 && !err_in[16] && err_in != 17'd0, esum_ff >= $past(esum_ff))

   // With a sane window the steering result lies inside it.
   `DSPS_ASSERT_NEXT(a_steer_window, ld4 && min_us_ff <= max_us_ff, steer_ff >= $past(min_us_ff) && steer_ff <= $past(max_us_ff))

endmodule
